/* rtl/core/wlrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrs_pkg
// Shared types and constants of the wear-levelled ring log store.
// ----------------------------------------------------------------------------
package wlrs_pkg;

    // CRC-16/MODBUS settings
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Command codes carried in the request transaction
    typedef enum logic [2:0] {
        CMD_SCAN  = 3'd0,
        CMD_STORE = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_RAW   = 3'd3,
        CMD_WORN  = 3'd4
    } cmd_t;

    // One slot of the ring as it lies in memory
    typedef struct packed {
        logic [15:0] crc;
        logic [7:0]  seq;
        logic [15:0] value;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Erased slot contents
    localparam slot_entry_t ERASED_ENTRY = '{crc: 16'hFFFF, seq: 8'hFF, value: 16'hFFFF};

endpackage

/* rtl/core/wlrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wlrs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and read port holding its last result
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/wlrs_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrs_crc
// Byte-serial CRC-16/MODBUS over value low byte, value high byte and sequence.
// One byte per cycle; done pulses once the sequence byte has been folded in.
// ----------------------------------------------------------------------------
module wlrs_crc
    import wlrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] value,
    input  logic [7:0]  seq,
    output logic        done,
    output logic [15:0] crc
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [23:0] data_reg, data_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cur_byte;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Pick the byte for this step
    always_comb begin
        case (cnt_reg)
            2'd0:    cur_byte = data_reg[7:0];
            2'd1:    cur_byte = data_reg[15:8];
            default: cur_byte = data_reg[23:16];
        endcase
    end

    // Advance one byte per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        data_next = data_reg;
        crc_next  = crc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            data_next = {seq, value};
            crc_next  = CRC_INIT;
        end else if (busy_reg) begin
            crc_next = crc_byte(crc_reg, cur_byte);
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        data_reg <= data_next;
        crc_reg  <= crc_next;
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

/* rtl/core/wear_leveled_ring_log_store.sv */
`timescale 1ns / 1ps
// Load, raw write, mark worn and unused codes go from idle through the response
// state to the output register. Scan visits the slots in turn with a memory read,
// a CRC start, then a wait until the byte-serial CRC is done; store repeats a
// read with CRC start and a check for each attempt. One command at a time; the
// next is taken while a result waits at the output. After reset a clearing pass
// erases the slot and wear memories; no command is accepted until it ends.
// ----------------------------------------------------------------------------
// wear_leveled_ring_log_store
// Ring log of CRC-protected slots with scan, store with verify, load, raw write and wear marking.
// ----------------------------------------------------------------------------
module wear_leveled_ring_log_store
    import wlrs_pkg::*;
#(
    parameter int SLOT_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], slot[10:3], entry_value[26:11], raw_seq[34:27], raw_crc[50:35]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], result_slot[8:1], read_value[24:9], found_seq[32:25]
    output logic [39:0] m_tdata
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int XW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CRC,
        ST_SCAN_CHK,
        ST_STORE_RD,
        ST_STORE_CHK,
        ST_RESP
    } state_t;

    state_t       state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [15:0]  val_reg, val_next;
    logic [7:0]   seq_reg, seq_next;
    logic         started_reg, started_next;
    logic         found_reg, found_next;
    logic [7:0]   gap_reg, gap_next;
    logic [7:0]   last_reg, last_next;
    logic [AW-1:0] at_reg, at_next;
    logic [15:0]  at_val_reg, at_val_next;
    logic         ok_reg, ok_next;
    logic [AW-1:0] newest_slot_reg, newest_slot_next;
    logic         newest_known_reg, newest_known_next;
    logic [15:0]  newest_value_reg, newest_value_next;
    logic [7:0]   newest_seq_reg, newest_seq_next;
    logic         m_valid_reg, m_valid_next;
    logic [39:0]  m_data_reg, m_data_next;

    // Request fields
    logic [2:0]   in_cmd;
    logic [7:0]   in_slot;
    logic [15:0]  in_value;
    logic [7:0]   in_seq;
    logic [15:0]  in_crc;
    logic [XW-1:0] slot_ext;
    logic         slot_in_range;
    logic [AW-1:0] slot_addr;

    // Memory ports
    logic         ent_wr_en;
    logic [AW-1:0] ent_wr_addr;
    slot_entry_t  ent_wr_data;
    slot_entry_t  ent_rd_data;
    logic         worn_wr_en;
    logic [AW-1:0] worn_wr_addr;
    logic         worn_wr_data;
    logic         worn_rd_data;
    logic         rd_en;

    // CRC unit
    logic         crc_start;
    logic [15:0]  crc_value;
    logic [7:0]   crc_seq;
    logic         crc_done;
    logic [15:0]  crc_out;

    slot_entry_t  expect_entry;
    logic [XW-1:0] newest_ext;
    logic         accept;

    assign in_cmd   = s_tdata[2:0];
    assign in_slot  = s_tdata[10:3];
    assign in_value = s_tdata[26:11];
    assign in_seq   = s_tdata[34:27];
    assign in_crc   = s_tdata[50:35];

    assign slot_ext      = XW'(in_slot);
    assign slot_in_range = slot_ext < XW'(SLOT_COUNT);
    assign slot_addr     = slot_ext[AW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign expect_entry = '{crc: crc_out, seq: seq_reg, value: val_reg};
    assign newest_ext   = XW'(newest_slot_reg);

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    wlrs_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (ent_rd_data)
    );

    wlrs_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_worn_ram (
        .aclk    (aclk),
        .wr_en   (worn_wr_en),
        .wr_addr (worn_wr_addr),
        .wr_data (worn_wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (worn_rd_data)
    );

    wlrs_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crc_start),
        .value   (crc_value),
        .seq     (crc_seq),
        .done    (crc_done),
        .crc     (crc_out)
    );

    // Sequence the commands over the memories
    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        val_next          = val_reg;
        seq_next          = seq_reg;
        started_next      = started_reg;
        found_next        = found_reg;
        gap_next          = gap_reg;
        last_next         = last_reg;
        at_next           = at_reg;
        at_val_next       = at_val_reg;
        ok_next           = ok_reg;
        newest_slot_next  = newest_slot_reg;
        newest_known_next = newest_known_reg;
        newest_value_next = newest_value_reg;
        newest_seq_next   = newest_seq_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        ent_wr_en    = 1'b0;
        ent_wr_addr  = idx_reg;
        ent_wr_data  = ERASED_ENTRY;
        worn_wr_en   = 1'b0;
        worn_wr_addr = idx_reg;
        worn_wr_data = 1'b0;
        rd_en        = 1'b0;
        crc_start    = 1'b0;
        crc_value    = val_reg;
        crc_seq      = seq_reg;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ent_wr_en  = 1'b1;
                worn_wr_en = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    ok_next    = 1'b0;
                    state_next = ST_RESP;
                    case (in_cmd)
                        CMD_SCAN: begin
                            idx_next     = '0;
                            started_next = 1'b0;
                            found_next   = 1'b0;
                            gap_next     = 8'd1;
                            last_next    = 8'hFF;
                            state_next   = ST_SCAN_RD;
                        end
                        CMD_STORE: begin
                            val_next   = in_value;
                            seq_next   = newest_seq_reg + 8'd1;
                            idx_next   = newest_known_reg ? next_idx(newest_slot_reg) : '0;
                            cnt_next   = '0;
                            state_next = ST_STORE_RD;
                        end
                        CMD_LOAD: begin
                            ok_next = newest_known_reg;
                        end
                        CMD_RAW: begin
                            if (slot_in_range) begin
                                ent_wr_en   = 1'b1;
                                ent_wr_addr = slot_addr;
                                ent_wr_data = '{crc: in_crc, seq: in_seq, value: in_value};
                                ok_next     = 1'b1;
                            end
                        end
                        CMD_WORN: begin
                            if (slot_in_range) begin
                                worn_wr_en   = 1'b1;
                                worn_wr_addr = slot_addr;
                                worn_wr_data = 1'b1;
                                ok_next      = 1'b1;
                            end
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SCAN_CRC;
            end

            ST_SCAN_CRC: begin
                crc_start  = 1'b1;
                crc_value  = ent_rd_data.value;
                crc_seq    = ent_rd_data.seq;
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK: begin
                if (crc_done) begin
                    if (crc_out == ent_rd_data.crc) begin
                        if (started_reg && (ent_rd_data.seq != last_reg + gap_reg)) begin
                            // Sequence break: stop the walk here
                            state_next = ST_RESP;
                        end else begin
                            started_next = 1'b1;
                            found_next   = 1'b1;
                            gap_next     = 8'd1;
                            at_next      = idx_reg;
                            at_val_next  = ent_rd_data.value;
                            last_next    = ent_rd_data.seq;
                        end
                    end else begin
                        gap_next = gap_reg + 8'd1;
                    end
                    if (state_next != ST_RESP) begin
                        if (idx_reg == LAST_IDX) begin
                            state_next = ST_RESP;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_SCAN_RD;
                        end
                    end
                    // Commit the newest entry at the end of the walk
                    if (state_next == ST_RESP) begin
                        newest_known_next = found_next;
                        ok_next           = found_next;
                        if (found_next) begin
                            newest_slot_next  = at_next;
                            newest_value_next = at_val_next;
                            newest_seq_next   = last_next;
                        end
                    end
                end
            end

            ST_STORE_RD: begin
                rd_en      = 1'b1;
                crc_start  = 1'b1;
                state_next = ST_STORE_CHK;
            end

            ST_STORE_CHK: begin
                if (crc_done) begin
                    if (!worn_rd_data || (ent_rd_data == expect_entry)) begin
                        ent_wr_en         = !worn_rd_data;
                        ent_wr_data       = expect_entry;
                        newest_slot_next  = idx_reg;
                        newest_known_next = 1'b1;
                        newest_value_next = val_reg;
                        newest_seq_next   = seq_reg;
                        ok_next           = 1'b1;
                        state_next        = ST_RESP;
                    end else if (cnt_reg == LAST_IDX) begin
                        ok_next    = 1'b0;
                        state_next = ST_RESP;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        idx_next   = next_idx(idx_reg);
                        seq_next   = seq_reg + 8'd1;
                        state_next = ST_STORE_RD;
                    end
                end
            end

            ST_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0,
                                    newest_known_reg ? newest_seq_reg : 8'd0,
                                    newest_known_reg ? newest_value_reg : 16'd0,
                                    newest_known_reg ? newest_ext[7:0] : 8'd0,
                                    ok_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            started_reg      <= 1'b0;
            found_reg        <= 1'b0;
            ok_reg           <= 1'b0;
            newest_slot_reg  <= '0;
            newest_known_reg <= 1'b0;
            newest_value_reg <= 16'd0;
            newest_seq_reg   <= 8'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            cnt_reg          <= cnt_next;
            started_reg      <= started_next;
            found_reg        <= found_next;
            ok_reg           <= ok_next;
            newest_slot_reg  <= newest_slot_next;
            newest_known_reg <= newest_known_next;
            newest_value_reg <= newest_value_next;
            newest_seq_reg   <= newest_seq_next;
            m_valid_reg      <= m_valid_next;
        end
        val_reg    <= val_next;
        seq_reg    <= seq_next;
        gap_reg    <= gap_next;
        last_reg   <= last_next;
        at_reg     <= at_next;
        at_val_reg <= at_val_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* verif/tb_wear_leveled_ring_log_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wear_leveled_ring_log_store
// Drives scan, store, load, raw write, mark-worn and unused-code transactions into the
// ring log store and checks every answer against a behavioural predictor of
// the slot ring, wear mask and newest-entry state.
// ----------------------------------------------------------------------------
module tb_wear_leveled_ring_log_store
    import wlrs_pkg::*;
;

    localparam int NSLOT = 256;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [7:0]  found_seq;
        logic [15:0] read_value;
        logic [7:0]  result_slot;
        logic        ok;
    } answer_t;

    // Predictor of the log store plus a queue of expected answers
    class log_scoreboard;
        slot_entry_t ring [NSLOT];
        bit          worn [NSLOT];
        int unsigned top_slot;
        bit          top_known;
        logic [15:0] top_value;
        logic [7:0]  top_seq;
        answer_t     pending [$];
        int          mismatches;
        int          checked;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                ring[i] = ERASED_ENTRY;
                worn[i] = 0;
            end
            top_slot = 0; top_known = 0; top_value = 0; top_seq = 0;
            mismatches = 0; checked = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            return c;
        endfunction

        function logic [15:0] check_word(logic [15:0] v, logic [7:0] s);
            logic [15:0] c;
            c = crc_step(16'hFFFF, v[7:0]);
            c = crc_step(c, v[15:8]);
            return crc_step(c, s);
        endfunction

        function bit walk_ring();
            bit started, found;
            logic [7:0] last, gap;
            int unsigned at;
            started = 0; found = 0; last = 8'hFF; gap = 8'd1; at = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (ring[i].crc == check_word(ring[i].value, ring[i].seq)) begin
                    if (!started) started = 1;
                    else if (ring[i].seq != 8'(last + gap)) break;
                    gap = 8'd1; found = 1; at = i; last = ring[i].seq;
                end else begin
                    gap = 8'(gap + 1);
                end
            end
            top_known = found;
            if (found) begin
                top_slot = at; top_value = ring[at].value; top_seq = ring[at].seq;
            end
            return found;
        endfunction

        function bit append_entry(logic [15:0] v);
            logic [7:0] s;
            int unsigned at;
            slot_entry_t e;
            s = top_seq;
            at = top_known ? (top_slot + 1) % NSLOT : 0;
            for (int n = 0; n < NSLOT; n++) begin
                s = 8'(s + 1);
                e = '{crc: check_word(v, s), seq: s, value: v};
                if (!worn[at]) ring[at] = e;
                if (ring[at] == e) begin
                    top_slot = at; top_known = 1; top_value = v; top_seq = s;
                    return 1;
                end
                at = (at + 1) % NSLOT;
            end
            return 0;
        endfunction

        // Note an accepted request and queue its answer
        function void note_request(logic [55:0] d);
            logic [2:0] c;
            logic [7:0] sl;
            answer_t a;
            bit ok;
            c = d[2:0]; sl = d[10:3]; ok = 0;
            case (c)
                CMD_SCAN:  ok = walk_ring();
                CMD_STORE: ok = append_entry(d[26:11]);
                CMD_LOAD:  ok = top_known;
                CMD_RAW: begin
                    ring[sl] = '{crc: d[50:35], seq: d[34:27], value: d[26:11]};
                    ok = 1;
                end
                CMD_WORN: begin
                    worn[sl] = 1; ok = 1;
                end
                default: ok = 0;
            endcase
            a.ok = ok;
            a.result_slot = top_known ? 8'(top_slot) : 8'd0;
            a.read_value = top_known ? top_value : 16'd0;
            a.found_seq = top_known ? top_seq : 8'd0;
            pending.push_back(a);
        endfunction

        // Compare one accepted answer with the oldest expectation
        function void check_answer(logic [39:0] d);
            answer_t got, exp;
            got = d[32:0];
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected answer %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: ok %0d/%0d slot %0d/%0d value %h/%h seq %0d/%0d (exp/got)",
                             exp.ok, got.ok, exp.result_slot, got.result_slot,
                             exp.read_value, got.read_value, exp.found_seq, got.found_seq);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;

    log_scoreboard sb;
    bit calm = 0;
    int idle_cycles = 0;
    int stores_sent = 0;

    wear_leveled_ring_log_store #(.SLOT_COUNT(NSLOT)) u_dut (.*);

    always #4 aclk = ~aclk;

    // Note requests and check answers at each transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_answer(m_tdata);
        end
    end

    // Receiver side: random stall bursts, none in the calm phase
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function logic [55:0] pack_req(cmd_t c, logic [7:0] sl, logic [15:0] v,
                                   logic [7:0] rs, logic [15:0] rc);
        return {5'd0, rc, rs, v, sl, c};
    endfunction

    // Offer one request and hold it until accepted; the caller drops tvalid
    task automatic send_req(logic [55:0] d);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Plant a well-formed entry directly into a slot
    task automatic plant(logic [7:0] sl, logic [15:0] v, logic [7:0] s);
        send_req(pack_req(CMD_RAW, sl, v, s, sb.check_word(v, s)));
    endtask

    // Drop the request line and wait for every answer
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic random_req();
        int pick;
        logic [7:0] sl;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        sl = 8'($urandom_range(0, 255));
        v = 16'($urandom);
        if (pick < 30) begin
            if (stores_sent < 120) begin
                stores_sent++;
                send_req(pack_req(CMD_STORE, sl, v, 8'($urandom), 16'($urandom)));
            end else send_req(pack_req(CMD_LOAD, sl, v, 8'd0, 16'd0));
        end
        else if (pick < 45) send_req(pack_req(CMD_LOAD, sl, v, 8'($urandom), 16'($urandom)));
        else if (pick < 53) send_req(pack_req(CMD_SCAN, sl, v, 8'($urandom), 16'($urandom)));
        else if (pick < 73) plant(sl, v, 8'($urandom));
        else if (pick < 83)
            plant(8'(sb.top_slot + 1), v, 8'(sb.top_seq + $urandom_range(1, 3)));
        else if (pick < 90) send_req(pack_req(CMD_RAW, sl, v, 8'($urandom), 16'($urandom)));
        else if (pick < 94) send_req(pack_req(CMD_WORN, sl, v, 8'($urandom), 16'($urandom)));
        else send_req({5'd0, 16'($urandom), 8'($urandom), v, sl, 3'($urandom_range(5, 7))});
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // Directed: empty ring, extremes, each command and unused codes
        send_req(pack_req(CMD_LOAD, 8'd0, 16'd0, 8'd0, 16'd0));
        send_req(pack_req(CMD_SCAN, 8'd0, 16'd0, 8'd0, 16'd0));
        send_req(pack_req(CMD_STORE, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_req(pack_req(CMD_STORE, 8'd0, 16'h0000, 8'd0, 16'd0));
        send_req(pack_req(CMD_LOAD, 8'd0, 16'd0, 8'd0, 16'd0));
        // sequence wrap through 0xFF around a corrupted slot
        plant(8'd10, 16'h1234, 8'hFE);
        plant(8'd11, 16'h5678, 8'hFF);
        send_req(pack_req(CMD_RAW, 8'd12, 16'hAAAA, 8'h55, 16'h0000));
        plant(8'd13, 16'h9ABC, 8'h01);
        plant(8'd14, 16'hDEF0, 8'h07);
        send_req(pack_req(CMD_SCAN, 8'd0, 16'd0, 8'd0, 16'd0));
        // mark slots worn, then store again
        send_req(pack_req(CMD_WORN, 8'd14, 16'd0, 8'd0, 16'd0));
        send_req(pack_req(CMD_WORN, 8'd15, 16'd0, 8'd0, 16'd0));
        send_req(pack_req(CMD_STORE, 8'd0, 16'hC0DE, 8'd0, 16'd0));
        send_req(pack_req(CMD_RAW, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_req(pack_req(CMD_WORN, 8'hFF, 16'd0, 8'd0, 16'd0));
        send_req(pack_req(CMD_STORE, 8'd0, 16'h0001, 8'd0, 16'd0));
        send_req({5'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 3'd5});
        send_req({5'd0, 16'd0, 8'd0, 16'd0, 8'd0, 3'd6});
        send_req({5'd0, 16'd0, 8'd0, 16'd0, 8'd0, 3'd7});
        send_req(pack_req(CMD_SCAN, 8'd0, 16'd0, 8'd0, 16'd0));

        // Hold off until every answer has come back
        drain();

        for (int i = 0; i < 500; i++) begin
            if (i == 420) calm = 1;
            random_req();
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("Covered %0d answers over scan, store with wear, load, raw write and worn marks.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
